/* rtl/r2a_pkg.sv */
// shared types, constants and the digit-to-ascii mapping for the radix converter
// no dependencies
`timescale 1ns / 1ps

package r2a_pkg;

  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [DIGIT_W-1:0] DEC_DIGITS  = 6'd10;

  // '0' and ('a' - 10)
  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_LETTERS = 7'd87;
  localparam logic [CHAR_W-1:0] ASCII_NUL     = 7'd0;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ACC  = 4'b0010,
    S_EMIT = 4'b0100,
    S_BAD  = 4'b1000
  } state_t;

  // control shared by every digit cell
  typedef struct packed {
    logic               clear;
    logic               shift;
    logic [DIGIT_W-1:0] radix;
  } cell_ctrl_t;

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < DEC_DIGITS) begin
      return ASCII_ZERO + dx;
    end
    return ASCII_LETTERS + dx;
  endfunction

endpackage

/* rtl/r2a_cell.sv */
// one digit cell of the systolic radix accumulator: digit <- 2*digit + carry mod radix
// depends on r2a_pkg
`timescale 1ns / 1ps

module r2a_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  r2a_pkg::cell_ctrl_t         ctrl,
  input  logic                        step_in,
  input  logic                        carry_in,
  input  logic [r2a_pkg::DIGIT_W-1:0] shift_in,
  output logic                        step_out,
  output logic                        carry_out,
  output logic [r2a_pkg::DIGIT_W-1:0] digit
);

  logic [r2a_pkg::DIGIT_W:0]   twice;
  logic [r2a_pkg::DIGIT_W:0]   radix_x;
  logic                        wrap;
  logic [r2a_pkg::DIGIT_W:0]   reduced;

  // digit stays below radix, so one subtract is enough
  assign twice   = {digit, carry_in};
  assign radix_x = {1'b0, ctrl.radix};
  assign wrap    = (twice >= radix_x);
  assign reduced = wrap ? (twice - radix_x) : twice;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_out <= 1'b0;
    end else begin
      step_out <= step_in;
    end
  end

  always_ff @(posedge clk) begin
    carry_out <= wrap && step_in;
    if (ctrl.clear) begin
      digit <= '0;
    end else if (step_in) begin
      digit <= reduced[r2a_pkg::DIGIT_W-1:0];
    end else if (ctrl.shift) begin
      digit <= shift_in;
    end
  end

endmodule

/* rtl/radix_integer_to_ascii.sv */
// top level of the integer to ascii converter: control, input shifter, cell row, output beat
// depends on r2a_pkg and r2a_cell
`timescale 1ns / 1ps

// Converts an unsigned integer (low VALUE_BITS bits of value) into its digits in the base
// held in the radix register (written through cfg_wr_en / cfg_wr_data, reset 10), as
// lower-case ascii, most significant digit first, last set on the final beat. Zero gives
// the single digit '0'. A radix outside 2..36 gives one beat with digit_char 0, last 1 and
// bad_base 1. The value is shifted in msb first, one bit per cycle, into a row of
// VALUE_BITS digit cells; each bit ripples up the row one cell per cycle. The row is
// then shifted out one digit per cycle while the output is not stalled, with leading
// zeros dropped. The next value is taken while the last beat of the previous one still
// waits in the output register.

module radix_integer_to_ascii #(
  parameter int VALUE_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [r2a_pkg::DIGIT_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [63:0]                 value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [r2a_pkg::CHAR_W-1:0]  digit_char,
  output logic                        last,
  output logic                        bad_base
);

  localparam int CW = $clog2(VALUE_BITS + 1);
  localparam logic [CW-1:0] TOP_IDX = CW'(VALUE_BITS - 1);
  localparam logic [CW-1:0] N_BITS  = CW'(VALUE_BITS);

  r2a_pkg::state_t             state;
  r2a_pkg::state_t             state_next;
  logic [r2a_pkg::DIGIT_W-1:0] radix;
  logic [VALUE_BITS-1:0]       shifter;
  logic [CW-1:0]               cnt;
  logic                        started;

  r2a_pkg::cell_ctrl_t         ctrl;
  logic [VALUE_BITS:0]         step;
  logic [VALUE_BITS-1:0]       carry;
  logic [r2a_pkg::DIGIT_W-1:0] dig [VALUE_BITS];

  logic in_fire;
  logic radix_bad;
  logic slot_free;
  logic feeding;
  logic acc_done;
  logic emit_now;
  logic [r2a_pkg::DIGIT_W-1:0] top_digit;

  assign in_ready  = (state == r2a_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign radix_bad = (radix < r2a_pkg::RADIX_MIN) || (radix > r2a_pkg::RADIX_MAX);
  assign slot_free = !out_valid || out_ready;
  assign feeding   = (state == r2a_pkg::S_ACC) && (cnt < N_BITS);
  // last cell has taken its final step once its token is out and the one below is empty
  assign acc_done  = step[VALUE_BITS] && !step[VALUE_BITS-1];
  assign top_digit = dig[VALUE_BITS-1];
  // leading zeros are dropped, but the lowest digit always goes out
  assign emit_now  = started || (top_digit != '0) || (cnt == TOP_IDX);

  assign ctrl.clear = in_fire && !radix_bad;
  assign ctrl.shift = (state == r2a_pkg::S_EMIT) && slot_free;
  assign ctrl.radix = radix;

  // bit feed into the bottom of the row, msb first
  assign step[0]  = feeding;
  assign carry[0] = shifter[VALUE_BITS-1];

  for (genvar i = 0; i < VALUE_BITS; i++) begin : g_cell
    logic [r2a_pkg::DIGIT_W-1:0] below;
    if (i == 0) begin : g_bottom
      assign below = '0;
    end else begin : g_upper
      assign below = dig[i-1];
    end
    if (i < VALUE_BITS - 1) begin : g_mid
      r2a_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .step_in   (step[i]),
        .carry_in  (carry[i]),
        .shift_in  (below),
        .step_out  (step[i+1]),
        .carry_out (carry[i+1]),
        .digit     (dig[i])
      );
    end else begin : g_top
      // the value always fits the row, so the top carry is always zero
      r2a_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .step_in   (step[i]),
        .carry_in  (carry[i]),
        .shift_in  (below),
        .step_out  (step[i+1]),
        .carry_out (),
        .digit     (dig[i])
      );
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      r2a_pkg::S_IDLE: begin
        if (in_fire) begin
          state_next = radix_bad ? r2a_pkg::S_BAD : r2a_pkg::S_ACC;
        end
      end
      r2a_pkg::S_ACC: begin
        if (acc_done) begin
          state_next = r2a_pkg::S_EMIT;
        end
      end
      r2a_pkg::S_EMIT: begin
        if (slot_free && (cnt == TOP_IDX)) begin
          state_next = r2a_pkg::S_IDLE;
        end
      end
      r2a_pkg::S_BAD: begin
        if (slot_free) begin
          state_next = r2a_pkg::S_IDLE;
        end
      end
      default: state_next = r2a_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= r2a_pkg::S_IDLE;
      radix     <= r2a_pkg::RADIX_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        radix <= cfg_wr_data;
      end
      if ((state == r2a_pkg::S_BAD) && slot_free) begin
        out_valid <= 1'b1;
      end else if ((state == r2a_pkg::S_EMIT) && slot_free && emit_now) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath and sequencing counters
  always_ff @(posedge clk) begin
    if (in_fire) begin
      shifter <= value[VALUE_BITS-1:0];
      cnt     <= '0;
    end else if (feeding) begin
      shifter <= {shifter[VALUE_BITS-2:0], 1'b0};
      cnt     <= cnt + CW'(1);
    end else if ((state == r2a_pkg::S_ACC) && acc_done) begin
      cnt     <= '0;
      started <= 1'b0;
    end else if (ctrl.shift) begin
      cnt     <= cnt + CW'(1);
      started <= started || emit_now;
    end

    if ((state == r2a_pkg::S_BAD) && slot_free) begin
      digit_char <= r2a_pkg::ASCII_NUL;
      last       <= 1'b1;
      bad_base   <= 1'b1;
    end else if (ctrl.shift && emit_now) begin
      digit_char <= r2a_pkg::to_ascii(top_digit);
      last       <= (cnt == TOP_IDX);
      bad_base   <= 1'b0;
    end
  end

endmodule
